FILE: rtl/core/qxh_pkg.sv
package qxh_pkg;

   localparam int WIDTH_BITS_DEFAULT = 160;
   localparam int SHIFT_DEFAULT      = 11;
   localparam int COUNT_BITS         = 64;

   localparam int OP_W    = 1;
   localparam int DATA_W  = 8;
   localparam int INDEX_W = 5;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_PAD_W   = RSP_TDATA_W - DATA_W - INDEX_W;

   localparam logic [OP_W-1:0] OP_ABSORB = 1'b0;
   localparam logic [OP_W-1:0] OP_FINISH = 1'b1;

endpackage

FILE: rtl/core/quickxor_hash_engine_core.sv
// Channel   Ports                               Beat
// -------   ---------------------------------   ---------------------------------------
// req       req_tvalid/tready/tdata/tuser       one message byte or a finish command
// rsp       rsp_tvalid/tready/tdata/tlast       one digest byte, low byte first
//
// An absorb beat passes a registered input stage that feeds a single rotate-and-XOR into
// the accumulator, so bytes stream at one per clock while no finish waits in that stage.
// A finish beat snapshots the digest into an output shift register and clears the state;
// its (WIDTH_BITS+7)/8 digest beats then drain at the result port rate while later bytes
// keep streaming in. A second finish waits in the input stage until the previous digest
// has left, so the output shift register sets the finish rate.
// Reset is synchronous and active high and clears the accumulator, position and count.
module quickxor_hash_engine_core #(
   parameter int WIDTH_BITS = qxh_pkg::WIDTH_BITS_DEFAULT,
   parameter int SHIFT      = qxh_pkg::SHIFT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [qxh_pkg::REQ_TDATA_W-1:0] req_tdata,   // [7:0] data_byte
   input  logic [qxh_pkg::OP_W-1:0]        req_tuser,   // [0] op
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [qxh_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // [7:0] digest_byte, [12:8] byte_index
   output logic                            rsp_tlast    // last
);
   import qxh_pkg::*;

   localparam int DIG_BYTES = (WIDTH_BITS + 7) / 8;
   localparam int DIG_W     = DIG_BYTES * 8;
   localparam int POS_W     = $clog2(WIDTH_BITS);
   localparam int IDX_W     = $clog2(DIG_BYTES);
   localparam int SHIFT_MOD = SHIFT % WIDTH_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIG_BYTES - 1);

   logic                  in_valid_ff, in_valid_in;
   logic [OP_W-1:0]       in_op_ff;
   logic [DATA_W-1:0]     in_data_ff;

   logic [WIDTH_BITS-1:0] acc_ff, acc_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic                  out_valid_ff, out_valid_in;
   logic [DIG_W-1:0]      dig_ff, dig_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;

   logic                  out_take;
   logic                  buf_free;
   logic                  in_go;
   logic                  do_absorb;
   logic                  do_finish;
   logic [WIDTH_BITS+7:0] place;
   logic [WIDTH_BITS-1:0] mask;
   logic [POS_W:0]        pos_sum;
   logic [DIG_W-1:0]      digest;

   assign out_take   = out_valid_ff && rsp_tready;
   assign buf_free   = !out_valid_ff || (out_take && (idx_ff == LAST_IDX));
   assign in_go      = in_valid_ff && ((in_op_ff == OP_ABSORB) || buf_free);
   assign do_absorb  = in_go && (in_op_ff == OP_ABSORB);
   assign do_finish  = in_go && (in_op_ff == OP_FINISH);
   assign req_tready = !in_valid_ff || in_go;

   assign place   = (WIDTH_BITS + 8)'(in_data_ff) << pos_ff;
   assign mask    = place[WIDTH_BITS-1:0] ^ WIDTH_BITS'(place[WIDTH_BITS+7:WIDTH_BITS]);
   assign pos_sum = {1'b0, pos_ff} + (POS_W + 1)'(SHIFT_MOD);
   assign digest  = DIG_W'(acc_ff) ^ (DIG_W'(count_ff) << (DIG_W - COUNT_BITS));

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
   end

   always_comb begin
      acc_in   = acc_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      if (do_finish) begin
         acc_in   = '0;
         pos_in   = '0;
         count_in = '0;
      end else if (do_absorb) begin
         acc_in   = acc_ff ^ mask;
         count_in = count_ff + COUNT_BITS'(1);
         if (pos_sum >= (POS_W + 1)'(WIDTH_BITS)) begin
            pos_in = POS_W'(pos_sum - (POS_W + 1)'(WIDTH_BITS));
         end else begin
            pos_in = pos_sum[POS_W-1:0];
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      dig_in       = dig_ff;
      idx_in       = idx_ff;
      if (do_finish) begin
         out_valid_in = 1'b1;
         dig_in       = digest;
         idx_in       = '0;
      end else if (out_take) begin
         if (idx_ff == LAST_IDX) begin
            out_valid_in = 1'b0;
         end else begin
            dig_in = dig_ff >> 8;
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
         pos_ff       <= '0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_op_ff   <= req_tuser;
         in_data_ff <= req_tdata[DATA_W-1:0];
      end
      dig_ff <= dig_in;
      idx_ff <= idx_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = (idx_ff == LAST_IDX);
   assign rsp_tdata  = {RSP_PAD_W'(0), INDEX_W'(idx_ff), dig_ff[DATA_W-1:0]};

endmodule

FILE: rtl/core/qxh_checker.sv
module qxh_checker #(
   parameter int WIDTH_BITS = qxh_pkg::WIDTH_BITS_DEFAULT
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [qxh_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import qxh_pkg::*;

   localparam int DIG_BYTES = (WIDTH_BITS + 7) / 8;
   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(DIG_BYTES - 1);

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // The final digest beat carries the last byte position.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[12:8] == LAST_INDEX)
      else $error("tlast on wrong digest position");

   // Digest beats follow each other without gaps and in order.
   a_next_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && rsp_tdata[12:8] == INDEX_W'($past(rsp_tdata[12:8]) + INDEX_W'(1)))
      else $error("digest beat missing or out of order");

   // A new digest starts at position zero.
   a_first_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid || rsp_tdata[12:8] == '0)
      else $error("digest does not start at byte zero");

   // Reset leaves no result pending and the input open.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind quickxor_hash_engine_core qxh_checker #(.WIDTH_BITS(WIDTH_BITS)) u_qxh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

FILE: test/quickxor_hash_engine_core_test.sv
module quickxor_hash_engine_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import qxh_pkg::*;

   localparam int HASH_BITS   = WIDTH_BITS_DEFAULT;
   localparam int DIGEST_LEN  = (HASH_BITS + 7) / 8;
   localparam int COUNT_LEN   = COUNT_BITS / 8;
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [DATA_W-1:0]  value;
      logic [INDEX_W-1:0] byte_pos;
      logic               is_last;
   } digest_beat_type;

   typedef struct {
      logic [OP_W-1:0]           op;
      logic [DATA_W-1:0]         data;
      int                        reps;
      bit                        known;
      logic [DIGEST_LEN*8-1:0]   digest;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [OP_W-1:0]        req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;

   logic [DIGEST_LEN*8-1:0] hash_acc;
   int                      hash_pos;
   logic [COUNT_BITS-1:0]   hash_count;
   digest_beat_type         digest_expect[$];
   stim_row_type            stim_table[$];

   bit                      row_known;
   logic [DIGEST_LEN*8-1:0] row_digest;
   bit                      hold_request;
   int                      burst_left;
   int                      error_count;
   int                      bytes_absorbed;
   int                      digests_done;
   int                      beats_checked;
   int                      idle_cycles;

   quickxor_hash_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin : digest_monitor
      int bit_k;
      int bit_pos;
      int idx;
      digest_beat_type beat;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_ABSORB) begin
               for (bit_k = 0; bit_k < DATA_W; bit_k++) begin
                  bit_pos = hash_pos + bit_k;
                  if (bit_pos >= HASH_BITS) bit_pos -= HASH_BITS;
                  hash_acc[bit_pos] ^= req_tdata[bit_k];
               end
               hash_pos = (hash_pos + SHIFT_DEFAULT) % HASH_BITS;
               hash_count = hash_count + 1'b1;
               bytes_absorbed++;
            end else begin
               for (idx = 0; idx < DIGEST_LEN; idx++) begin
                  if (row_known) begin
                     beat.value = row_digest[8*idx +: 8];
                  end else begin
                     beat.value = hash_acc[8*idx +: 8];
                     if (idx >= DIGEST_LEN - COUNT_LEN)
                        beat.value ^= hash_count[8*(idx - (DIGEST_LEN - COUNT_LEN)) +: 8];
                  end
                  beat.byte_pos = INDEX_W'(idx);
                  beat.is_last  = (idx == DIGEST_LEN - 1);
                  digest_expect.push_back(beat);
               end
               hash_acc   = '0;
               hash_pos   = 0;
               hash_count = '0;
               digests_done++;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (digest_expect.size() == 0) begin
               $error("unexpected digest beat: tdata %h tlast %b", rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               beat = digest_expect.pop_front();
               if (rsp_tdata[DATA_W-1:0] !== beat.value) begin
                  $error("digest_byte: expected %h, got %h", beat.value, rsp_tdata[DATA_W-1:0]);
                  error_count++;
               end
               if (rsp_tdata[DATA_W +: INDEX_W] !== beat.byte_pos) begin
                  $error("byte_index: expected %0d, got %0d", beat.byte_pos,
                         rsp_tdata[DATA_W +: INDEX_W]);
                  error_count++;
               end
               if (rsp_tlast !== beat.is_last) begin
                  $error("last: expected %b, got %b", beat.is_last, rsp_tlast);
                  error_count++;
               end
               beats_checked++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("Timeout: no beat moved for %0d cycles.", STALL_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // The receiver switches between stall patterns and honors one long hold-off on request.
   initial begin : digest_receiver
      int mode;
      int mode_left;
      int phase;
      int hold_left;
      mode = 0;
      mode_left = 0;
      phase = 0;
      hold_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         phase++;
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= (phase % 4 != 3);
               default: rsp_tready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data,
                            input bit known, input logic [DIGEST_LEN*8-1:0] digest);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= op;
      row_known  = known;
      row_digest = digest;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_for_digests();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      wait (digest_expect.size() == 0);
   endtask

   task automatic add_row(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data,
                          input int reps, input bit known,
                          input logic [DIGEST_LEN*8-1:0] digest);
      stim_row_type row;
      row.op     = op;
      row.data   = data;
      row.reps   = reps;
      row.known  = known;
      row.digest = digest;
      stim_table.push_back(row);
   endtask

   initial begin : stimulus
      int random_items;
      int msg_len;
      int pick;
      bit paused;
      logic [DATA_W-1:0] data;
      stim_row_type row;

      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_ABSORB;
      reset      = 1'b1;
      hash_acc   = '0;
      hash_pos   = 0;
      hash_count = '0;
      row_known  = 1'b0;
      row_digest = '0;
      hold_request = 1'b0;
      burst_left = 0;
      error_count = 0;
      bytes_absorbed = 0;
      digests_done = 0;
      beats_checked = 0;
      random_items = 0;
      paused = 1'b0;

      // Empty message, single extreme bytes and a byte split across the top of the circle
      // with predicted digests, then single bytes and back-to-back finishes.
      add_row(OP_FINISH, 8'h00, 1, 1'b1, '0);
      add_row(OP_ABSORB, 8'hff, 1, 1'b0, '0);
      add_row(OP_FINISH, 8'hff, 1, 1'b1, (160'h01 << 96) | 160'hff);
      add_row(OP_ABSORB, 8'h00, 14, 1'b0, '0);
      add_row(OP_ABSORB, 8'hff, 1, 1'b0, '0);
      add_row(OP_FINISH, 8'h00, 1, 1'b1,
              (160'hfc << 152) | (160'h0f << 96) | 160'h03);
      add_row(OP_ABSORB, 8'h80, 1, 1'b0, '0);
      add_row(OP_ABSORB, 8'h01, 1, 1'b0, '0);
      add_row(OP_ABSORB, 8'ha5, 3, 1'b0, '0);
      add_row(OP_FINISH, 8'h5a, 1, 1'b0, '0);
      add_row(OP_FINISH, 8'h00, 1, 1'b0, '0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[r]) begin
         row = stim_table[r];
         repeat (row.reps) send_item(row.op, row.data, row.known, row.digest);
      end
      wait_for_digests();

      // Hold the result side while finishes pile up so the input stalls.
      hold_request = 1'b1;
      repeat (3) begin
         repeat (2) send_item(OP_ABSORB, 8'($urandom_range(0, 255)), 1'b0, '0);
         send_item(OP_FINISH, 8'($urandom_range(0, 255)), 1'b0, '0);
         random_items += 3;
      end

      while (random_items < 120) begin
         msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48)
                                               : $urandom_range(0, 12);
         repeat (msg_len) begin
            pick = $urandom_range(0, 9);
            data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom_range(0, 255));
            send_item(OP_ABSORB, data, 1'b0, '0);
            random_items++;
         end
         send_item(OP_FINISH, 8'($urandom_range(0, 255)), 1'b0, '0);
         random_items++;
         if (!paused && random_items > 60) begin
            wait_for_digests();
            paused = 1'b1;
         end
      end

      wait_for_digests();
      repeat (40) @(posedge clock);
      $display("Absorbed %0d message bytes over %0d finishes; %0d digest beats checked.",
               bytes_absorbed, digests_done, beats_checked);
      $display("Covered empty messages, placement wrap past the top bit, back-to-back finishes,");
      $display("and a long result stall that backed up the input.");
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
